// ===== src/shift_jis_decoder_core_defines.svh =====
// Assertion macros used by the checker file of the Shift-JIS decoder.
`ifndef SHIFT_JIS_DECODER_CORE_DEFINES_SVH
`define SHIFT_JIS_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SJIS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sjis assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SJIS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sjis assertion failed");

`endif

// ===== src/sjis_pkg.sv =====
`timescale 1ns / 1ps

package sjis_pkg;

    // Kind of an item handed from the front end to the back end.
    localparam logic [1:0] KIND_ASCII = 2'd0;
    localparam logic [1:0] KIND_KANA  = 2'd1;
    localparam logic [1:0] KIND_PAIR  = 2'd2;

    // Charset tags of a result.
    localparam logic [3:0] CS_ASCII = 4'd0;
    localparam logic [3:0] CS_KANA  = 4'd1;
    localparam logic [3:0] CS_X0208 = 4'd2;
    localparam logic [3:0] CS_APPLE = 4'd3;
    localparam logic [3:0] CS_VEND1 = 4'd4;
    localparam logic [3:0] CS_VEND2 = 4'd5;
    localparam logic [3:0] CS_VRAW  = 4'd6;
    localparam logic [3:0] CS_P1    = 4'd7;
    localparam logic [3:0] CS_P2    = 4'd8;

    // Code sizes.
    localparam logic [1:0] SIZE_SINGLE = 2'd1;
    localparam logic [1:0] SIZE_PAIR   = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_IDX_X0213  = 1'b0;
    localparam logic CFG_IDX_VENDOR = 1'b1;

    // Depth of the queue between front and back end.
    localparam int QUEUE_DEPTH = 2;

    // Classified item carried through the queue.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic       x0213;
        logic       vendor;
    } item_t;

    // Result item, charset in the lowest bits.
    typedef struct packed {
        logic       bad_sequence;
        logic [1:0] code_size;
        logic [7:0] code_lo;
        logic [7:0] code_hi;
        logic [3:0] charset;
    } result_t;

    // JIS X 0213 plane 2 row for lead bytes 0xF0..0xFC, chosen by the half.
    function automatic logic [7:0] p2_row(input logic [3:0] idx, input logic second);
        logic [7:0] row;
        row = 8'h00;
        case (idx)
            4'd0:    row = second ? 8'h28 : 8'h21;
            4'd1:    row = second ? 8'h24 : 8'h23;
            4'd2:    row = second ? 8'h2c : 8'h25;
            4'd3:    row = second ? 8'h2e : 8'h2d;
            4'd4:    row = second ? 8'h6e : 8'h2f;
            4'd5:    row = second ? 8'h70 : 8'h6f;
            4'd6:    row = second ? 8'h72 : 8'h71;
            4'd7:    row = second ? 8'h74 : 8'h73;
            4'd8:    row = second ? 8'h76 : 8'h75;
            4'd9:    row = second ? 8'h78 : 8'h77;
            4'd10:   row = second ? 8'h7a : 8'h79;
            4'd11:   row = second ? 8'h7c : 8'h7b;
            4'd12:   row = second ? 8'h7e : 8'h7d;
            default: row = 8'h00;
        endcase
        return row;
    endfunction

endpackage

// ===== src/sjis_front.sv =====
`timescale 1ns / 1ps

module sjis_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic                cfg_data,
    input  logic                queue_full,
    output logic                push,
    output sjis_pkg::item_t     push_item
);

    logic       lead_pending_reg;
    logic       lead_pending_next;
    logic [7:0] lead_byte_reg;
    logic [7:0] lead_byte_next;
    logic       x0213_reg;
    logic       vendor_reg;
    logic       accept;
    logic       is_ascii;
    logic       is_kana;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x0213_reg  <= 1'b0;
            vendor_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == sjis_pkg::CFG_IDX_X0213)
                x0213_reg <= cfg_data;
            else
                vendor_reg <= cfg_data;
        end
    end

    // A beat is taken whenever the queue has room.
    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign is_ascii = (s_tdata <= 8'h7e);
    assign is_kana  = (s_tdata >= 8'ha1) && (s_tdata <= 8'hdf);

    // Classify the byte: complete a pair, pass a single byte, or hold a lead.
    always_comb
    begin
        lead_pending_next = lead_pending_reg;
        lead_byte_next    = lead_byte_reg;
        push              = 1'b0;
        push_item.kind    = sjis_pkg::KIND_PAIR;
        push_item.byte1   = lead_byte_reg;
        push_item.byte2   = s_tdata;
        push_item.x0213   = x0213_reg;
        push_item.vendor  = vendor_reg;
        if (accept)
        begin
            if (lead_pending_reg)
            begin
                push              = 1'b1;
                lead_pending_next = 1'b0;
            end
            else if (is_ascii || is_kana)
            begin
                push            = 1'b1;
                push_item.kind  = is_ascii ? sjis_pkg::KIND_ASCII : sjis_pkg::KIND_KANA;
                push_item.byte1 = s_tdata;
                push_item.byte2 = 8'h00;
            end
            else
            begin
                lead_pending_next = 1'b1;
                lead_byte_next    = s_tdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_pending_reg <= 1'b0;
            lead_byte_reg    <= 8'h00;
        end
        else
        begin
            lead_pending_reg <= lead_pending_next;
            lead_byte_reg    <= lead_byte_next;
        end
    end

endmodule

// ===== src/sjis_queue.sv =====
`timescale 1ns / 1ps

module sjis_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sjis_pkg::item_t     push_item,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output sjis_pkg::item_t     head_item
);

    localparam int PTR_W = (sjis_pkg::QUEUE_DEPTH > 1) ? $clog2(sjis_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(sjis_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(sjis_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(sjis_pkg::QUEUE_DEPTH);

    sjis_pkg::item_t  mem_reg [sjis_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== src/sjis_back.sv =====
`timescale 1ns / 1ps

module sjis_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  sjis_pkg::item_t     head_item,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata
);

    logic                out_valid_reg;
    sjis_pkg::result_t   result_reg;
    sjis_pkg::result_t   result_next;
    logic [7:0]          c1;
    logic [7:0]          c2;
    logic [15:0]         code;
    logic [3:0]          cs;
    logic [7:0]          t;
    logic                first_half;
    logic                second_half;
    logic [7:0]          jis_cell;
    logic [7:0]          row_base;
    logic [7:0]          row;
    logic                lead_low;
    logic                lead_high;
    logic                lead_p2;

    assign c1   = head_item.byte1;
    assign c2   = head_item.byte2;
    assign code = {c1, c2};

    // Charset tag from the mode registers captured with the pair.
    always_comb
    begin
        if (head_item.x0213)
            cs = (c1 >= 8'hf0) ? sjis_pkg::CS_P2 : sjis_pkg::CS_P1;
        else if (head_item.vendor)
        begin
            if ((code >= 16'h8540 && code <= 16'h886d) ||
                (code >= 16'heb41 && code <= 16'hed96))
                cs = sjis_pkg::CS_APPLE;
            else
                cs = sjis_pkg::CS_X0208;
        end
        else if (code >= 16'h8740 && code <= 16'h879c)
            cs = sjis_pkg::CS_VEND1;
        else if (code >= 16'hed40 && code <= 16'heefc)
            cs = sjis_pkg::CS_VEND2;
        else if (code >= 16'hfa40 && code <= 16'hfc4b)
            cs = sjis_pkg::CS_VRAW;
        else
            cs = sjis_pkg::CS_X0208;
    end

    // Cell and row arithmetic; a trail at or above 0x80 is first moved down by one.
    assign t           = c2 - {7'b0, c2[7]};
    assign second_half = (t >= 8'h9e) && (t <= 8'hfb);
    assign first_half  = (t >= 8'h40) && (t <= 8'h9d);
    assign jis_cell    = second_half ? (t - 8'h7d) : (t - 8'h1f);
    assign lead_low    = (c1 >= 8'h81) && (c1 <= 8'h9f);
    assign lead_high   = (c1 >= 8'he0) && (c1 <= 8'hfc);
    assign lead_p2     = (c1 >= 8'hf0) && (c1 <= 8'hfc);
    assign row_base    = lead_low ? (c1 - 8'h71) : (c1 - 8'hb1);
    assign row         = {row_base[6:0], 1'b1} + {7'b0, second_half};

    // Result of the item at the head of the queue.
    always_comb
    begin
        result_next.charset      = cs;
        result_next.code_hi      = c1;
        result_next.code_lo      = c2;
        result_next.code_size    = sjis_pkg::SIZE_PAIR;
        result_next.bad_sequence = 1'b0;
        case (head_item.kind)
            sjis_pkg::KIND_ASCII:
            begin
                result_next.charset   = sjis_pkg::CS_ASCII;
                result_next.code_lo   = 8'h00;
                result_next.code_size = sjis_pkg::SIZE_SINGLE;
            end
            sjis_pkg::KIND_KANA:
            begin
                result_next.charset   = sjis_pkg::CS_KANA;
                result_next.code_hi   = {1'b0, c1[6:0]};
                result_next.code_lo   = 8'h00;
                result_next.code_size = sjis_pkg::SIZE_SINGLE;
            end
            default:
            begin
                if (cs == sjis_pkg::CS_VRAW)
                begin
                    // The raw vendor range passes the bytes unchanged.
                end
                else if (!first_half && !second_half)
                    result_next.bad_sequence = 1'b1;
                else if (cs == sjis_pkg::CS_P2)
                begin
                    if (lead_p2)
                    begin
                        result_next.code_hi = sjis_pkg::p2_row(c1[3:0], second_half);
                        result_next.code_lo = jis_cell;
                    end
                    else
                        result_next.bad_sequence = 1'b1;
                end
                else if (lead_low || lead_high)
                begin
                    result_next.code_hi = row;
                    result_next.code_lo = jis_cell;
                end
                else
                    result_next.bad_sequence = 1'b1;
            end
        endcase
    end

    // Output register: refilled whenever it is empty or its beat is taken.
    assign pop = head_valid && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, result_reg};

endmodule

// ===== src/shift_jis_decoder_core.sv =====
`timescale 1ns / 1ps

// Shift-JIS decoder core. One byte is taken on the input stream every cycle while the
// two-entry queue between the classifying front end and the decoding back end has room.
// A single-byte character gives one result beat, a lead byte gives none and is held,
// and the following trail byte gives one result beat for the pair. A result is written
// into the queue and then into the output register before it is offered on the output;
// the sustained rate is one byte per cycle and is set by the output register's
// handshake, so the input stalls only when the output side is stalled and the queue
// has filled. Mode registers take effect for pairs completed after the write.
module shift_jis_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream; s_tdata bits [7:0] in_byte.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // Output stream; m_tdata bits [3:0] charset, [11:4] code_hi, [19:12] code_lo,
    // [21:20] code_size, [22] bad_sequence, [23] zero.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    // Configuration write: index 0 x0213_mode, index 1 vendor_variant.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic        cfg_data
);

    logic            queue_full;
    logic            push;
    sjis_pkg::item_t push_item;
    logic            pop;
    logic            head_valid;
    sjis_pkg::item_t head_item;

    // Front end: byte intake, lead tracking and mode registers.
    sjis_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    // Queue between the two halves.
    sjis_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Back end: conversion and output register.
    sjis_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== src/sjis_checker.sv =====
`timescale 1ns / 1ps
`include "shift_jis_decoder_core_defines.svh"

module sjis_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata
);

    // A stalled output beat stays offered.
    `SJIS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

    // Every result carries one or two code bytes.
    `SJIS_ASSERT_NOW(a_size_legal, m_tvalid, m_tdata[21:20] == 2'd1 || m_tdata[21:20] == 2'd2)

    // A single-byte result has no second byte, is never an error and is tagged ASCII or kana.
    `SJIS_ASSERT_NOW(a_single_clean, m_tvalid && m_tdata[21:20] == 2'd1,
                     m_tdata[19:12] == 8'h00 && !m_tdata[22] && m_tdata[3:1] == 3'd0)

    // Charset tags stop at plane 2 and the pad bit stays clear.
    `SJIS_ASSERT_NOW(a_charset_range, m_tvalid, m_tdata[3:0] <= 4'd8 && !m_tdata[23])

endmodule

bind shift_jis_decoder_core sjis_checker u_sjis_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
